// ----- rtl/sfid_pkg.sv -----
// Shared types and constants for the smallest-free-ID allocator.
// Holds the set size, field widths, controller states and datapath command/status.
`default_nettype none

package sfid_pkg;

    localparam int SET_SIZE = 1024;
    localparam int ID_W     = 11;
    localparam int IDX_W    = $clog2(SET_SIZE);
    localparam int CNT_W    = $clog2(SET_SIZE + 1);
    // child index of the deepest slot needs room for 2*(SET_SIZE-1)+2
    localparam int CHD_W    = IDX_W + 2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_POP_ROOT,
        S_POP_LAST,
        S_POP_TAKE,
        S_DN_L,
        S_DN_R,
        S_DN_C,
        S_RES,
        S_EMPTY,
        S_ADD_RD,
        S_ADD_TAKE,
        S_UP_R,
        S_UP_C
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_CAPTURE,
        OP_RD_ROOT,
        OP_RD_LAST,
        OP_POP_TAKE,
        OP_DN_RDL,
        OP_DN_RDR,
        OP_DN_STEP,
        OP_LOAD_OUT,
        OP_LOAD_EMPTY,
        OP_ADD_RD,
        OP_ADD_TAKE,
        OP_UP_RD,
        OP_UP_STEP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic empty;
        logic add_ok;
        logic dn_leaf;
        logic dn_move;
        logic up_root;
        logic up_move;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/sfid_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module sfid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/sfid_ctrl.sv -----
// Sequencer for the allocator: init sweep, pop with sift-down, add-back with sift-up.
// Depends on sfid_pkg; drives the datapath through t_dp_cmd and reads t_dp_sts.
`default_nettype none

module sfid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  sfid_pkg::t_dp_sts i_sts,
    output logic              o_stall,
    output sfid_pkg::t_dp_cmd o_cmd
);

    import sfid_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = i_kind ? S_ADD_RD : S_POP_ROOT;
            end
            S_POP_ROOT: begin
                n_state = i_sts.empty ? S_EMPTY : S_POP_LAST;
            end
            S_POP_LAST: n_state = S_POP_TAKE;
            S_POP_TAKE: n_state = S_DN_L;
            S_DN_L: begin
                n_state = i_sts.dn_leaf ? S_RES : S_DN_R;
            end
            S_DN_R: n_state = S_DN_C;
            S_DN_C: begin
                n_state = i_sts.dn_move ? S_DN_L : S_RES;
            end
            S_RES, S_EMPTY: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_ADD_RD: n_state = S_ADD_TAKE;
            S_ADD_TAKE: begin
                n_state = i_sts.add_ok ? S_UP_R : S_IDLE;
            end
            S_UP_R: begin
                n_state = i_sts.up_root ? S_IDLE : S_UP_C;
            end
            S_UP_C: begin
                n_state = i_sts.up_move ? S_UP_R : S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_stall  = (r_state != S_IDLE);
        o_cmd.op = OP_NOP;
        case (r_state)
            S_INIT:     o_cmd.op = OP_INIT;
            S_IDLE:     o_cmd.op = i_valid ? OP_CAPTURE : OP_NOP;
            S_POP_ROOT: o_cmd.op = i_sts.empty ? OP_NOP : OP_RD_ROOT;
            S_POP_LAST: o_cmd.op = OP_RD_LAST;
            S_POP_TAKE: o_cmd.op = OP_POP_TAKE;
            S_DN_L:     o_cmd.op = OP_DN_RDL;
            S_DN_R:     o_cmd.op = OP_DN_RDR;
            S_DN_C:     o_cmd.op = OP_DN_STEP;
            S_RES:      o_cmd.op = i_sts.out_free ? OP_LOAD_OUT : OP_NOP;
            S_EMPTY:    o_cmd.op = i_sts.out_free ? OP_LOAD_EMPTY : OP_NOP;
            S_ADD_RD:   o_cmd.op = OP_ADD_RD;
            S_ADD_TAKE: o_cmd.op = OP_ADD_TAKE;
            S_UP_R:     o_cmd.op = OP_UP_RD;
            S_UP_C:     o_cmd.op = OP_UP_STEP;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sfid_dp.sv -----
// Datapath for the allocator: heap RAM, presence-flag RAM, count, sift cursor, result register.
// Depends on sfid_pkg and sfid_ram; sequenced by sfid_ctrl through t_dp_cmd.
`default_nettype none

module sfid_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfid_pkg::t_dp_cmd           i_cmd,
    input  logic [sfid_pkg::ID_W-1:0]   i_value,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [sfid_pkg::ID_W-1:0]   o_smallest,
    output logic                        o_set_empty,
    output sfid_pkg::t_dp_sts           o_sts
);

    import sfid_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_init;
    logic [IDX_W-1:0] r_pos;
    logic [ID_W-1:0]  r_x;
    logic [ID_W-1:0]  r_id;
    logic [ID_W-1:0]  r_lval;
    logic [ID_W-1:0]  r_value;
    logic             r_out_valid;
    logic [ID_W-1:0]  r_smallest;
    logic             r_empty;

    logic             heap_we;
    logic [IDX_W-1:0] heap_waddr;
    logic [ID_W-1:0]  heap_wdata;
    logic [IDX_W-1:0] heap_raddr;
    logic [ID_W-1:0]  heap_rdata;
    logic             flag_we;
    logic [IDX_W-1:0] flag_waddr;
    logic             flag_wdata;
    logic [IDX_W-1:0] flag_raddr;
    logic             flag_rdata;

    logic [CHD_W-1:0] left;
    logic [CHD_W-1:0] right;
    logic [CHD_W-1:0] cnt_ext;
    logic             left_ok;
    logic             right_ok;
    logic             right_take;
    logic [ID_W-1:0]  cand_val;
    logic [IDX_W-1:0] cand_idx;
    logic             dn_move;
    logic             up_move;
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] pos_m1;
    logic [CNT_W-1:0] cnt_m1;
    logic [ID_W-1:0]  val_m1;
    logic [ID_W-1:0]  id_m1;
    logic             in_range;
    logic             add_ok;
    logic             out_free;

    sfid_ram #(.WIDTH(ID_W), .DEPTH(SET_SIZE)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    sfid_ram #(.WIDTH(1), .DEPTH(SET_SIZE)) u_flag (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (flag_raddr),
        .o_rdata (flag_rdata)
    );

    // children of the cursor, compared against the live count
    assign left     = {1'b0, r_pos, 1'b1};
    assign right    = left + CHD_W'(1);
    assign cnt_ext  = CHD_W'(r_count);
    assign left_ok  = (left < cnt_ext);
    assign right_ok = (right < cnt_ext);

    // right child data is on the read port during the step; left was held in r_lval
    assign right_take = right_ok && (heap_rdata < r_lval);
    assign cand_val   = right_take ? heap_rdata : r_lval;
    assign cand_idx   = right_take ? right[IDX_W-1:0] : left[IDX_W-1:0];
    assign dn_move    = (cand_val < r_x);

    assign pos_m1  = r_pos - IDX_W'(1);
    assign parent  = pos_m1 >> 1;
    assign up_move = (heap_rdata > r_x);

    assign cnt_m1   = r_count - CNT_W'(1);
    assign val_m1   = r_value - ID_W'(1);
    assign id_m1    = r_id - ID_W'(1);
    assign in_range = (r_value != '0) && (r_value <= ID_W'(SET_SIZE));
    assign add_ok   = in_range && !flag_rdata && (r_count < CNT_W'(SET_SIZE));
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        heap_we    = 1'b0;
        heap_waddr = r_pos;
        heap_wdata = r_x;
        heap_raddr = '0;
        flag_we    = 1'b0;
        flag_waddr = id_m1[IDX_W-1:0];
        flag_wdata = 1'b0;
        flag_raddr = val_m1[IDX_W-1:0];
        case (i_cmd.op)
            OP_INIT: begin
                heap_we    = 1'b1;
                heap_waddr = r_init;
                heap_wdata = ID_W'(r_init) + ID_W'(1);
                flag_we    = 1'b1;
                flag_waddr = r_init;
                flag_wdata = 1'b1;
            end
            OP_RD_ROOT: heap_raddr = '0;
            OP_RD_LAST: heap_raddr = cnt_m1[IDX_W-1:0];
            OP_POP_TAKE: begin
                flag_we = 1'b1;
            end
            OP_DN_RDL: begin
                heap_raddr = left[IDX_W-1:0];
                // no children left: drop the carried entry into the hole
                heap_we    = !left_ok;
            end
            OP_DN_RDR: heap_raddr = right[IDX_W-1:0];
            OP_DN_STEP: begin
                heap_we    = 1'b1;
                heap_wdata = dn_move ? cand_val : r_x;
            end
            OP_ADD_TAKE: begin
                flag_we    = add_ok;
                flag_waddr = val_m1[IDX_W-1:0];
                flag_wdata = 1'b1;
            end
            OP_UP_RD: begin
                heap_raddr = parent;
                heap_we    = (r_pos == '0);
            end
            OP_UP_STEP: begin
                heap_we    = 1'b1;
                heap_wdata = up_move ? heap_rdata : r_x;
            end
            default: begin
                heap_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_W'(SET_SIZE);
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_INIT:     r_init  <= r_init + IDX_W'(1);
                OP_POP_TAKE: r_count <= cnt_m1;
                OP_ADD_TAKE: begin
                    if (add_ok) r_count <= r_count + CNT_W'(1);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
            if (i_cmd.op == OP_LOAD_OUT || i_cmd.op == OP_LOAD_EMPTY) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: r_value <= i_value;
            OP_RD_LAST: r_id    <= heap_rdata;
            OP_POP_TAKE: begin
                r_x   <= heap_rdata;
                r_pos <= '0;
            end
            OP_DN_RDR: r_lval <= heap_rdata;
            OP_DN_STEP: begin
                if (dn_move) r_pos <= cand_idx;
            end
            OP_ADD_TAKE: begin
                r_x   <= r_value;
                r_pos <= r_count[IDX_W-1:0];
            end
            OP_UP_STEP: begin
                if (up_move) r_pos <= parent;
            end
            OP_LOAD_OUT: begin
                r_smallest <= r_id;
                r_empty    <= 1'b0;
            end
            OP_LOAD_EMPTY: begin
                r_smallest <= ID_W'(SET_SIZE + 1);
                r_empty    <= 1'b1;
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_smallest  = r_smallest;
    assign o_set_empty = r_empty;

    assign o_sts.init_last = (r_init == IDX_W'(SET_SIZE - 1));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.add_ok    = add_ok;
    assign o_sts.dn_leaf   = !left_ok;
    assign o_sts.dn_move   = dn_move;
    assign o_sts.up_root   = (r_pos == '0);
    assign o_sts.up_move   = up_move;
    assign o_sts.out_free  = out_free;

endmodule

`default_nettype wire

// ----- rtl/smallest_free_id_allocator.sv -----
// Smallest-free-ID allocator over IDs 1..1024, kept as a binary min-heap in a
// 1024x11 RAM with a 1024x1 presence-flag RAM. After reset the block runs a
// sweep that loads both RAMs, holding o_stall high. It handles one item at a
// time and holds o_stall high until it is through with it. A pop reads the
// root and the last entry, then sifts the carried entry down; the single read
// port of the heap RAM means each level reads both children and writes one
// entry. An empty pop goes straight to the result. An add-back that is dropped
// returns to idle; otherwise it sifts the new entry up, reading the parent and
// writing one entry per level. It gives no result. A result sits in an
// output register, so the next item is taken while it waits; a pop that
// finishes while the previous result still waits holds until that transfer.
`default_nettype none

module smallest_free_id_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_kind,
    input  logic [sfid_pkg::ID_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [sfid_pkg::ID_W-1:0] o_smallest,
    output logic                      o_set_empty
);

    import sfid_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    sfid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    sfid_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_smallest  (o_smallest),
        .o_set_empty (o_set_empty),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// ----- rtl/sfid_chk.sv -----
// Port-level checker for the allocator, bound to the top level.
// Depends on sfid_pkg for the set size and ID width.
`default_nettype none

module sfid_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      i_kind,
    input logic [sfid_pkg::ID_W-1:0] i_value,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [sfid_pkg::ID_W-1:0] o_smallest,
    input logic                      o_set_empty
);

    import sfid_pkg::*;

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_smallest) && $stable(o_set_empty))
        else $error("result changed while stalled");

    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_set_empty |-> o_smallest == ID_W'(SET_SIZE + 1))
        else $error("empty pop with wrong ID");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_set_empty |-> o_smallest != '0 && o_smallest <= ID_W'(SET_SIZE))
        else $error("popped ID out of range");

    // init sweep blocks input and nothing is pending right out of reset
    a_reset_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_stall && !o_valid)
        else $error("block not held after reset");

endmodule

bind smallest_free_id_allocator sfid_chk u_chk (.*);

`default_nettype wire

// ----- dv/smallest_free_id_allocator_tb.sv -----
// Testbench for smallest_free_id_allocator: pops and add-backs with random pacing,
// checked against a presence-set predictor. Depends on rtl/sfid_pkg.sv and the block.
`timescale 1ns / 100ps

module smallest_free_id_allocator_tb;
    import sfid_pkg::*;

    localparam logic KIND_POP    = 1'b0;
    localparam logic KIND_ADD    = 1'b1;
    localparam int   CYCLE_LIMIT = 1_000_000;
    localparam int   SETTLE_CYC  = 40;

    typedef struct packed {
        logic [ID_W-1:0] smallest;
        logic            set_empty;
    } t_grant;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_valid     = 1'b0;
    logic            i_kind      = KIND_POP;
    logic [ID_W-1:0] i_value     = '0;
    logic            i_stall     = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic [ID_W-1:0] o_smallest;
    logic            o_set_empty;

    // free-ID pool as the block should see it
    bit     id_present [1:SET_SIZE];
    int     pool_count;
    t_grant pending_grants[$];

    int fail_count  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    bit stall_on    = 1'b0;

    smallest_free_id_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_smallest  (o_smallest),
        .o_set_empty (o_set_empty)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void pool_reset();
        for (int id = 1; id <= SET_SIZE; id++) begin
            id_present[id] = 1'b1;
        end
        pool_count = SET_SIZE;
    endfunction

    function automatic t_grant pool_take_smallest();
        t_grant g;
        g.smallest  = ID_W'(SET_SIZE + 1);
        g.set_empty = 1'b1;
        for (int id = 1; id <= SET_SIZE && g.set_empty; id++) begin
            if (id_present[id]) begin
                g.smallest     = ID_W'(id);
                g.set_empty    = 1'b0;
                id_present[id] = 1'b0;
                pool_count--;
            end
        end
        return g;
    endfunction

    function automatic void pool_return(logic [ID_W-1:0] id);
        if (id >= 1 && id <= SET_SIZE && !id_present[id]) begin
            id_present[id] = 1'b1;
            pool_count++;
        end
    endfunction

    // mostly the low IDs, where pops and add-backs keep colliding
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ID_W'(SET_SIZE);
            2, 3, 4: return ID_W'($urandom_range(0, SET_SIZE));
            default: return ID_W'($urandom_range(1, 48));
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    task automatic send_item(logic kind, logic [ID_W-1:0] value);
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (kind == KIND_POP) begin
            pending_grants.push_back(pool_take_smallest());
        end else begin
            pool_return(value);
        end
        // end the burst with a gap, else keep valid high
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_on   = !stall_on;
            stall_left = stall_on ? $urandom_range(0, 6) : $urandom_range(1, 30);
            i_stall   <= stall_on && stall_left != 0;
        end else begin
            stall_left--;
        end
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected result, smallest", int'(o_smallest), 0);
            end else begin
                want = pending_grants.pop_front();
                if (o_smallest !== want.smallest) begin
                    report_mismatch("smallest", int'(o_smallest), int'(want.smallest));
                end
                if (o_set_empty !== want.set_empty) begin
                    report_mismatch("set_empty", int'(o_set_empty), int'(want.set_empty));
                end
            end
        end
    end

    task automatic test_directed();
        send_item(KIND_POP, '0);
        send_item(KIND_POP, ID_W'(SET_SIZE));
        send_item(KIND_ADD, '0);                // out of range
        send_item(KIND_ADD, ID_W'(SET_SIZE));   // already present
        send_item(KIND_ADD, ID_W'(1023));
        send_item(KIND_ADD, ID_W'(2));
        send_item(KIND_ADD, ID_W'(2));          // duplicate add-back
        send_item(KIND_POP, '0);
        send_item(KIND_POP, ID_W'(1023));
        send_item(KIND_ADD, ID_W'(1));
        send_item(KIND_ADD, ID_W'(3));
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);
    endtask

    task automatic test_random_mix(int n_items, int add_pct);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(1, 100) <= add_pct) begin
                send_item(KIND_ADD, pick_id());
            end else begin
                send_item(KIND_POP, ID_W'($urandom_range(0, SET_SIZE)));
            end
        end
    endtask

    task automatic test_drain_to_empty();
        while (pool_count > 0) begin
            send_item(KIND_POP, ID_W'($urandom_range(0, SET_SIZE)));
        end
        repeat (3) send_item(KIND_POP, '0);
        send_item(KIND_ADD, '0);
        send_item(KIND_ADD, ID_W'(SET_SIZE));
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_ADD, ID_W'(1));
        send_item(KIND_ADD, ID_W'(SET_SIZE));
        send_item(KIND_ADD, ID_W'(1));
        repeat (3) send_item(KIND_POP, '0);
    endtask

    initial begin
        pool_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(60, 40);
        test_drain_to_empty();
        test_random_mix(60, 60);

        i_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- smallest_free_id_allocator.f -----
rtl/sfid_pkg.sv
rtl/sfid_ram.sv
rtl/sfid_ctrl.sv
rtl/sfid_dp.sv
rtl/smallest_free_id_allocator.sv
rtl/sfid_chk.sv
dv/smallest_free_id_allocator_tb.sv
